/* design/zb32_pkg.sv */
// shared types, constants and alphabet functions for the z-base-32 stream codec
// no dependencies; imported by every module of the block
package zb32_pkg;

    // direction register codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // apb register map: word index taken from paddr bit 2
    localparam int  PADDR_W       = 3;
    localparam logic REG_DIRECTION = 1'b0;

    // internal accumulator never holds more than seven bits
    localparam int ACC_W  = 7;
    localparam int PEND_W = 3;

    // input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_end;
    } t_out_item;

    // all results caused by one input item
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] vals;
        logic            last;
    } t_group;

    // configuration state seen by the datapath
    typedef struct packed {
        logic direction;
        logic clear;
    } t_cfg;

    // symbol lookup result
    typedef struct packed {
        logic       hit;
        logic [4:0] val;
    } t_sym;

    // 5-bit value to alphabet character
    function automatic logic [7:0] enc_char(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = "y";  5'd1:  c = "b";  5'd2:  c = "n";  5'd3:  c = "d";
            5'd4:  c = "r";  5'd5:  c = "f";  5'd6:  c = "g";  5'd7:  c = "8";
            5'd8:  c = "e";  5'd9:  c = "j";  5'd10: c = "k";  5'd11: c = "m";
            5'd12: c = "c";  5'd13: c = "p";  5'd14: c = "q";  5'd15: c = "x";
            5'd16: c = "o";  5'd17: c = "t";  5'd18: c = "1";  5'd19: c = "u";
            5'd20: c = "w";  5'd21: c = "i";  5'd22: c = "s";  5'd23: c = "z";
            5'd24: c = "a";  5'd25: c = "3";  5'd26: c = "4";  5'd27: c = "5";
            5'd28: c = "h";  5'd29: c = "7";  5'd30: c = "6";  5'd31: c = "9";
            default: c = "y";
        endcase
        return c;
    endfunction

    // character to 5-bit value, hit low for anything outside the alphabet
    function automatic t_sym dec_char(input logic [7:0] ch);
        t_sym s;
        s = '0;
        for (int k = 0; k < 32; k++) begin
            if (enc_char(5'(k)) == ch) begin
                s.hit = 1'b1;
                s.val = 5'(k);
            end
        end
        return s;
    endfunction

    // low-bit mask of r ones; r of seven wraps to all ones
    function automatic logic [ACC_W-1:0] low_mask(input logic [PEND_W-1:0] r);
        return (ACC_W'(1) << r) - ACC_W'(1);
    endfunction

endpackage

/* design/zbase32_stream_codec.sv */
// top level of the z-base-32 stream codec: apb register, datapath, result drain
// depends on zb32_pkg, zb32_cfg, zb32_core, zb32_drain
//
//  channel   signals                                 payload
//  input     i_in_valid / o_in_stall / i_in_data     t_in_item  (in_byte, in_last)
//  output    o_out_valid / i_out_stall / o_out_data  t_out_item (out_byte, run_last,
//                                                               message_end)
//  config    psel penable pwrite paddr pwdata prdata pready     (direction at 0x0)
//
// an item is worked out in the cycle it is taken and its results (none to three)
// pass through the group register and then the output register, one transfer per
// cycle while the output is not stalled; a byte giving several results stalls the
// input until its last one loads into the single output register (a decoded character gives at most one result).
// synchronous active-low reset clears direction, accumulator and both valids.
// an output stall holds the output register and, once the held group is
// pending, the input stall rises; a direction write clears the accumulator.
module zbase32_stream_codec
    import zb32_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_cfg   cfg;
    t_group group;
    logic   accept;

    // configuration register
    zb32_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // accumulator and per-item results
    zb32_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_in_data),
        .i_accept (accept),
        .o_group  (group)
    );

    // one result transfer per cycle while the output is not stalled
    zb32_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_group     (group),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* design/zb32_cfg.sv */
// apb configuration register: direction bit with a state clear pulse on write
// depends on zb32_pkg
module zb32_cfg
    import zb32_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic r_direction;
    logic n_direction;
    logic wr_hit;

    // write decode
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_DIRECTION);

    always_comb begin
        n_direction = r_direction;
        if (wr_hit) begin
            n_direction = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DIR_ENCODE;
        end else begin
            r_direction <= n_direction;
        end
    end

    // read data and status
    assign prdata = (paddr[2] == REG_DIRECTION) ? {31'd0, r_direction} : 32'd0;
    assign pready = 1'b1;

    assign o_cfg.direction = r_direction;
    assign o_cfg.clear     = wr_hit;

endmodule

/* design/zb32_core.sv */
// codec datapath: bit accumulator state and the per-item result computation
// depends on zb32_pkg
module zb32_core
    import zb32_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_in_item i_item,
    input  logic     i_accept,
    output t_group   o_group
);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;

    // encode side
    logic [11:0]       w_e;
    logic [3:0]        sum_e;
    logic [3:0]        s0_e;
    logic [3:0]        s1_e;
    logic              two_e;
    logic [PEND_W-1:0] rem_e;
    logic [4:0]        c0_e;
    logic [4:0]        c1_e;
    logic [4:0]        pad_e;
    logic [16:0]       pad_sh;
    logic              need_pad;

    // decode side
    t_sym              sym;
    logic [11:0]       w_d;
    logic [3:0]        sum_d;
    logic [3:0]        s_d;
    logic              emit_d;
    logic [PEND_W-1:0] rem_d;
    logic [7:0]        byte_d;

    logic [ACC_W-1:0]  step_acc;
    logic [PEND_W-1:0] step_pend;

    // encode: up to two full groups, then an optional zero-padded group
    always_comb begin
        w_e      = {r_acc[3:0], i_item.in_byte};
        sum_e    = {1'b0, r_pend} + 4'd8;
        two_e    = (sum_e >= 4'd10);
        s0_e     = sum_e - 4'd5;
        s1_e     = sum_e - 4'd10;
        c0_e     = w_e[s0_e +: 5];
        c1_e     = 5'(w_e >> s1_e);
        rem_e    = two_e ? PEND_W'(s1_e) : PEND_W'(s0_e);
        pad_sh   = {w_e, 5'd0} >> rem_e;
        pad_e    = pad_sh[4:0];
        need_pad = i_item.in_last && (rem_e != '0);
    end

    // decode: five bits per alphabet character, a byte once eight are held
    always_comb begin
        sym    = dec_char(i_item.in_byte);
        w_d    = {r_acc, sym.val};
        sum_d  = {1'b0, r_pend} + 4'd5;
        emit_d = (sum_d >= 4'd8);
        s_d    = sum_d - 4'd8;
        byte_d = 8'(w_d >> s_d);
        rem_d  = emit_d ? PEND_W'(s_d) : PEND_W'(sum_d);
    end

    // result group and state after the item
    always_comb begin
        o_group      = '0;
        o_group.last = i_item.in_last;
        step_acc     = r_acc;
        step_pend    = r_pend;
        if (i_cfg.direction == DIR_ENCODE) begin
            o_group.vals[0] = enc_char(c0_e);
            o_group.vals[1] = two_e ? enc_char(c1_e) : enc_char(pad_e);
            o_group.vals[2] = enc_char(pad_e);
            o_group.cnt     = 2'd1 + {1'b0, two_e} + {1'b0, need_pad};
            step_acc        = w_e[ACC_W-1:0] & low_mask(rem_e);
            step_pend       = rem_e;
        end else if (sym.hit) begin
            o_group.vals[0] = byte_d;
            o_group.cnt     = {1'b0, emit_d};
            step_acc        = w_d[ACC_W-1:0] & low_mask(rem_d);
            step_pend       = rem_d;
        end
    end

    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        if (i_cfg.clear) begin
            n_acc  = '0;
            n_pend = '0;
        end else if (i_accept) begin
            n_acc  = i_item.in_last ? '0 : step_acc;
            n_pend = i_item.in_last ? '0 : step_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
        end else begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

endmodule

/* design/zb32_drain.sv */
// result group register and output register, one result transfer per cycle while the output is not stalled
// depends on zb32_pkg
module zb32_drain
    import zb32_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_group    i_group,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    output logic      o_accept,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic      r_grp_valid;
    logic      n_grp_valid;
    t_group    r_grp;
    t_group    n_grp;
    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out;
    t_out_item n_out;

    logic      out_load;
    logic      is_final;
    logic      grp_done;
    logic      grp_free;
    logic [7:0] cur_byte;

    // pick the pending result of the held group
    always_comb begin
        case (r_idx)
            2'd0:    cur_byte = r_grp.vals[0];
            2'd1:    cur_byte = r_grp.vals[1];
            default: cur_byte = r_grp.vals[2];
        endcase
    end

    // handshake control
    assign out_load   = !r_out_valid || !i_out_stall;
    assign is_final   = (r_idx == r_grp.cnt - 2'd1);
    assign grp_done   = r_grp_valid && out_load && is_final;
    assign grp_free   = !r_grp_valid || grp_done;
    assign o_in_stall = !grp_free;
    assign o_accept   = i_in_valid && grp_free;

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (out_load) begin
            n_out_valid          = r_grp_valid;
            n_out.out_byte       = cur_byte;
            n_out.run_last       = is_final;
            n_out.message_end    = is_final && r_grp.last;
        end
    end

    // group register
    always_comb begin
        n_grp_valid = r_grp_valid;
        n_grp       = r_grp;
        n_idx       = r_idx;
        if (o_accept && (i_group.cnt != 2'd0)) begin
            n_grp_valid = 1'b1;
            n_grp       = i_group;
            n_idx       = 2'd0;
        end else if (grp_done) begin
            n_grp_valid = 1'b0;
        end else if (r_grp_valid && out_load) begin
            n_idx = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            r_grp_valid <= n_grp_valid;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
        r_grp <= n_grp;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
